>>> hw/rtl/display_window_fill_streamer_macros.svh
// Assertion macros shared by the window fill streamer RTL.
`ifndef DISPLAY_WINDOW_FILL_STREAMER_MACROS_SVH
`define DISPLAY_WINDOW_FILL_STREAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DWFS_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("dwfs assertion failed");

// Next-cycle implication, disabled during reset.
`define DWFS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("dwfs assertion failed");

`endif

>>> hw/rtl/dwfs_pkg.sv
// Types and constants of the display window fill streamer.
package dwfs_pkg;

    localparam int DWFS_MAX_SIDE = 1024;

    localparam int COORD_W = 16;
    localparam int SIDE_W  = 10;
    localparam int COUNT_W = 2 * SIDE_W;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_MEMORY = 8'h2C;

    typedef enum logic [3:0] {
        STEP_COL_CMD = 4'd0,
        STEP_X0_HI   = 4'd1,
        STEP_X0_LO   = 4'd2,
        STEP_X1_HI   = 4'd3,
        STEP_X1_LO   = 4'd4,
        STEP_ROW_CMD = 4'd5,
        STEP_Y0_HI   = 4'd6,
        STEP_Y0_LO   = 4'd7,
        STEP_Y1_HI   = 4'd8,
        STEP_Y1_LO   = 4'd9,
        STEP_MEM_CMD = 4'd10,
        STEP_PIXELS  = 4'd11
    } step_t;

endpackage

>>> hw/rtl/dwfs_req_if.sv
// Request channel: rectangle starts and ticks.
interface dwfs_req_if import dwfs_pkg::*;;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [SIDE_W-1:0]  width;
    logic [SIDE_W-1:0]  height;
    logic [COORD_W-1:0] color;

    modport source (
        output valid, kind, start_x, start_y, width, height, color,
        input  ready
    );
    modport sink (
        input  valid, kind, start_x, start_y, width, height, color,
        output ready
    );
endinterface

>>> hw/rtl/dwfs_item_if.sv
// Stream channel: panel write items.
interface dwfs_item_if import dwfs_pkg::*;;
    logic               valid;
    logic               ready;
    logic               is_data;
    logic               wide;
    logic [COORD_W-1:0] value;
    logic               last;

    modport source (
        output valid, is_data, wide, value, last,
        input  ready
    );
    modport sink (
        input  valid, is_data, wide, value, last,
        output ready
    );
endinterface

>>> hw/rtl/display_window_fill_streamer.sv
// Display window fill streamer: turns rectangle requests into a panel write stream.
//
// request: a transfer with kind = start latches a rectangle (start_x, start_y,
//   width, height, color) and restarts the stream; it gives no item. A transfer
//   with kind = tick gives the next stream item, or nothing while idle.
// stream: command 0x2A with x start/end bytes, 0x2B with y start/end bytes,
//   0x2C, then width*height pixel words; the final item has last set. An empty
//   rectangle ends with 0x2C flagged last. Sides above MAX_SIDE-1 are clamped.
// Output: each item is registered and appears on stream in the cycle after its tick transfer.
// Throughput: one request transfer per cycle unless stalled; the single output register is
//   the only storage between the channels, and it is reloaded in the cycle
//   it is taken.
// Stall: while the stream receiver holds off and the output register is full,
//   request.ready is low; nothing is dropped.
// Reset (rst_n low, asynchronous): the block goes idle with no item pending;
//   ticks give nothing until a start request arrives.
`include "display_window_fill_streamer_macros.svh"

module display_window_fill_streamer
    import dwfs_pkg::*;
#(
    parameter int MAX_SIDE = DWFS_MAX_SIDE
)
(
    input  logic        clk,
    input  logic        rst_n,
    dwfs_req_if.sink    request,
    dwfs_item_if.source stream
);

    localparam logic [16:0] SIDE_LIMIT = 17'(MAX_SIDE - 1);

    // Window state
    logic               active_reg, active_next;
    step_t              step_reg, step_next;
    logic [COUNT_W-1:0] pixels_left_reg, pixels_left_next;
    logic [COORD_W-1:0] x0_reg, x0_next;
    logic [COORD_W-1:0] y0_reg, y0_next;
    logic [COORD_W-1:0] x1_reg, x1_next;
    logic [COORD_W-1:0] y1_reg, y1_next;
    logic [COORD_W-1:0] color_reg, color_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_is_data_reg, out_is_data_next;
    logic               out_wide_reg, out_wide_next;
    logic [COORD_W-1:0] out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    logic               take;
    logic               produce;
    logic [SIDE_W-1:0]  side_w;
    logic [SIDE_W-1:0]  side_h;
    logic [COUNT_W-1:0] pixels_dec;

    assign request.ready = !out_valid_reg || stream.ready;
    assign take          = request.valid && request.ready;

    assign stream.valid   = out_valid_reg;
    assign stream.is_data = out_is_data_reg;
    assign stream.wide    = out_wide_reg;
    assign stream.value   = out_value_reg;
    assign stream.last    = out_last_reg;

    assign side_w = ({7'b0, request.width} > SIDE_LIMIT) ? SIDE_LIMIT[SIDE_W-1:0]
                                                         : request.width;
    assign side_h = ({7'b0, request.height} > SIDE_LIMIT) ? SIDE_LIMIT[SIDE_W-1:0]
                                                          : request.height;

    assign pixels_dec = (pixels_left_reg != '0) ? pixels_left_reg - COUNT_W'(1)
                                                : pixels_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            step_reg        <= STEP_COL_CMD;
            pixels_left_reg <= '0;
            x0_reg          <= '0;
            y0_reg          <= '0;
            x1_reg          <= '0;
            y1_reg          <= '0;
            color_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_reg      <= active_next;
            step_reg        <= step_next;
            pixels_left_reg <= pixels_left_next;
            x0_reg          <= x0_next;
            y0_reg          <= y0_next;
            x1_reg          <= x1_next;
            y1_reg          <= y1_next;
            color_reg       <= color_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_is_data_reg <= out_is_data_next;
        out_wide_reg    <= out_wide_next;
        out_value_reg   <= out_value_next;
        out_last_reg    <= out_last_next;
    end

    always_comb
    begin
        active_next      = active_reg;
        step_next        = step_reg;
        pixels_left_next = pixels_left_reg;
        x0_next          = x0_reg;
        y0_next          = y0_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        color_next       = color_reg;
        produce          = 1'b0;
        out_is_data_next = out_is_data_reg;
        out_wide_next    = out_wide_reg;
        out_value_next   = out_value_reg;
        out_last_next    = out_last_reg;

        if (take && request.kind == KIND_START)
        begin
            x0_next          = request.start_x;
            y0_next          = request.start_y;
            x1_next          = request.start_x + COORD_W'(side_w) - COORD_W'(1);
            y1_next          = request.start_y + COORD_W'(side_h) - COORD_W'(1);
            color_next       = request.color;
            pixels_left_next = {{SIDE_W{1'b0}}, side_w} * {{SIDE_W{1'b0}}, side_h};
            step_next        = STEP_COL_CMD;
            active_next      = 1'b1;
        end
        else if (take && active_reg)
        begin
            produce          = 1'b1;
            out_is_data_next = 1'b1;
            out_wide_next    = 1'b0;
            out_last_next    = 1'b0;
            step_next        = step_t'(step_reg + 4'd1);
            case (step_reg)
                STEP_COL_CMD:
                begin
                    out_is_data_next = 1'b0;
                    out_value_next   = {8'h00, CMD_COLUMN};
                end
                STEP_X0_HI: out_value_next = {8'h00, x0_reg[15:8]};
                STEP_X0_LO: out_value_next = {8'h00, x0_reg[7:0]};
                STEP_X1_HI: out_value_next = {8'h00, x1_reg[15:8]};
                STEP_X1_LO: out_value_next = {8'h00, x1_reg[7:0]};
                STEP_ROW_CMD:
                begin
                    out_is_data_next = 1'b0;
                    out_value_next   = {8'h00, CMD_ROW};
                end
                STEP_Y0_HI: out_value_next = {8'h00, y0_reg[15:8]};
                STEP_Y0_LO: out_value_next = {8'h00, y0_reg[7:0]};
                STEP_Y1_HI: out_value_next = {8'h00, y1_reg[15:8]};
                STEP_Y1_LO: out_value_next = {8'h00, y1_reg[7:0]};
                STEP_MEM_CMD:
                begin
                    out_is_data_next = 1'b0;
                    out_value_next   = {8'h00, CMD_MEMORY};
                    // empty window: memory write command closes the stream
                    if (pixels_left_reg == '0)
                    begin
                        out_last_next = 1'b1;
                        active_next   = 1'b0;
                        step_next     = STEP_COL_CMD;
                    end
                end
                default:
                begin
                    out_wide_next    = 1'b1;
                    out_value_next   = color_reg;
                    pixels_left_next = pixels_dec;
                    step_next        = STEP_PIXELS;
                    if (pixels_dec == '0)
                    begin
                        out_last_next = 1'b1;
                        active_next   = 1'b0;
                        step_next     = STEP_COL_CMD;
                    end
                end
            endcase
        end

        // hold a stalled item, drop it once taken
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    `DWFS_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, out_valid_reg && !stream.ready, !request.ready)
    `DWFS_ASSERT_NEXT(a_last_goes_idle, clk, rst_n, produce && out_last_next, !active_reg && stream.last)
    `DWFS_ASSERT_IMPLY(a_wide_is_data, clk, rst_n, stream.valid && stream.wide, stream.is_data)
    `DWFS_ASSERT_NEXT(a_start_restarts, clk, rst_n, take && request.kind == KIND_START, active_reg && step_reg == STEP_COL_CMD)

endmodule
